@@ rtl/fcc_pkg.sv @@
// ----------------------------------------------------------------------------
// fcc_pkg
// shared types and constants of the fat chain consistency checker
// ----------------------------------------------------------------------------
package fcc_pkg;

  localparam int unsigned FatDepthDef = 4096;
  localparam int unsigned MaxFilesDef = 32;

  // field widths
  localparam int unsigned ReqW   = 2;
  localparam int unsigned EntryW = 12;
  localparam int unsigned LinkW  = 13;
  localparam int unsigned BytesW = 31;
  localparam int unsigned FnumW  = 5;
  localparam int unsigned FreeW  = 13;
  localparam int unsigned BsW    = 11;
  localparam int unsigned FatSzW = 13;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDatW = 13;
  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 24;

  // request kinds
  localparam logic [ReqW-1:0] ReqLoad   = 2'd0;
  localparam logic [ReqW-1:0] ReqAppend = 2'd1;
  localparam logic [ReqW-1:0] ReqCheck  = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegBlockSize = 1'd0;
  localparam logic [CfgIdxW-1:0] RegFatSize   = 1'd1;

  localparam logic [BsW-1:0]    BlockSizeRst = 11'd512;
  localparam logic [FatSzW-1:0] FatSizeRst   = 13'd4096;

  typedef enum logic [3:0] {
    StIdle,
    StClear,
    StFileSel,
    StFileLoad,
    StIssue,
    StEval,
    StFileEnd,
    StEmit,
    StSummary
  } state_e;

  typedef struct packed {
    logic chk_start;
    logic clr_step;
    logic file_rd;
    logic chain_init;
    logic walk_rd;
    logic walk_eval;
    logic file_end;
    logic emit_init;
    logic emit_file;
    logic emit_sum;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic files_done;
    logic cur_ok;
    logic hit_loop;
    logic out_free;
  } status_t;

endpackage

@@ rtl/fat_chain_consistency_check.sv @@
// ----------------------------------------------------------------------------
// fat_chain_consistency_check
// checks the block chains of a file table for loops, sharing and length
// ----------------------------------------------------------------------------
// usage:
// - s_axis carries requests, tuser is the kind: load a table link, append a
//   file entry, or run a check; load and append return nothing
// - a check first clears min(fat_size, FAT_DEPTH) entries of the per-block
//   tag memory, then walks each file chain block by block (registered read
//   of the link and tag memories, then update)
// - m_axis then gives one result per file in load order and a summary
//   carrying the free block count, with tlast on the summary; one result per
//   cycle while the receiver is ready, the output register holds under stall
// - s_axis_tready is low from a check request until its summary is loaded
// - cfg writes are always accepted; write them only while no check runs
// - reset clears the file list and restores block_size 512, fat_size 4096;
//   the link table holds no reset value and must be loaded before it is used
// ----------------------------------------------------------------------------
module fat_chain_consistency_check import fcc_pkg::*; #(
  parameter int unsigned FatDepth = FatDepthDef,
  parameter int unsigned MaxFiles = MaxFilesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDatW-1:0]  cfg_data_i,
  // request stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // entry_index[11:0], next_block[24:12], file_first_block[37:25],
  // file_size[68:38], zero fill
  input  logic [InDataW-1:0]  s_axis_tdata,
  // req_type[1:0]
  input  logic [ReqW-1:0]     s_axis_tuser,
  // result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // file_number[4:0], too_few[5], too_many[6], has_loop[7], shares[8],
  // free_blocks[21:9], zero fill
  output logic [OutDataW-1:0] m_axis_tdata,
  // is_summary[0]
  output logic                m_axis_tuser,
  output logic                m_axis_tlast
);

  cmd_t    cmd;
  status_t status;
  state_e  state;
  logic    in_fire;

  assign cfg_ready_o = 1'b1;
  assign in_fire     = s_axis_tvalid && s_axis_tready;

  fcc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .in_req_i   (s_axis_tuser),
    .status_i   (status),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd),
    .state_o    (state)
  );

  fcc_datapath #(.FatDepth(FatDepth), .MaxFiles(MaxFiles)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_fire_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_fire_i     (in_fire),
    .in_req_i      (s_axis_tuser),
    .in_entry_i    (s_axis_tdata[11:0]),
    .in_next_i     (s_axis_tdata[24:12]),
    .in_first_i    (s_axis_tdata[37:25]),
    .in_bytes_i    (s_axis_tdata[68:38]),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_data_o    (m_axis_tdata),
    .out_summary_o (m_axis_tuser),
    .out_last_o    (m_axis_tlast)
  );

  // a check request always starts the clear pass
  a_check_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && s_axis_tuser == ReqCheck) |=> state == StClear)
    else $error("check request did not start a clear pass");

  // only the summary carries tlast
  a_last_is_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == m_axis_tuser))
    else $error("tlast on a result that is not the summary");

  // no request is taken while a check walks its chains
  a_busy_no_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state == StIssue || state == StEval) |-> !s_axis_tready)
    else $error("request channel ready during a chain walk");

endmodule

@@ rtl/fcc_ram.sv @@
// ----------------------------------------------------------------------------
// fcc_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module fcc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/fcc_ctrl.sv @@
// ----------------------------------------------------------------------------
// fcc_ctrl
// sequencer: clear pass, per-file chain walk, result emission
// ----------------------------------------------------------------------------
module fcc_ctrl import fcc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_fire_i,
  input  logic [ReqW-1:0] in_req_i,
  input  status_t         status_i,
  output logic            in_ready_o,
  output cmd_t            cmd_o,
  output state_e          state_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_fire_i && in_req_i == ReqCheck) begin
          cmd_o.chk_start = 1'b1;
          state_d = StClear;
        end
      end
      StClear: begin
        if (status_i.clr_done) begin
          state_d = StFileSel;
        end else begin
          cmd_o.clr_step = 1'b1;
        end
      end
      StFileSel: begin
        if (status_i.files_done) begin
          cmd_o.emit_init = 1'b1;
          state_d = StEmit;
        end else begin
          cmd_o.file_rd = 1'b1;
          state_d = StFileLoad;
        end
      end
      StFileLoad: begin
        cmd_o.chain_init = 1'b1;
        state_d = StIssue;
      end
      StIssue: begin
        if (status_i.cur_ok) begin
          cmd_o.walk_rd = 1'b1;
          state_d = StEval;
        end else begin
          state_d = StFileEnd;
        end
      end
      StEval: begin
        cmd_o.walk_eval = 1'b1;
        state_d = status_i.hit_loop ? StFileEnd : StIssue;
      end
      StFileEnd: begin
        cmd_o.file_end = 1'b1;
        state_d = StFileSel;
      end
      StEmit: begin
        if (status_i.files_done) begin
          state_d = StSummary;
        end else if (status_i.out_free) begin
          cmd_o.emit_file = 1'b1;
        end
      end
      StSummary: begin
        if (status_i.out_free) begin
          cmd_o.emit_sum = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign state_o = state_q;

endmodule

@@ rtl/fcc_datapath.sv @@
// ----------------------------------------------------------------------------
// fcc_datapath
// tables, chain walker registers, flags and the output register
// ----------------------------------------------------------------------------
module fcc_datapath import fcc_pkg::*; #(
  parameter int unsigned FatDepth = FatDepthDef,
  parameter int unsigned MaxFiles = MaxFilesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_fire_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgDatW-1:0] cfg_data_i,
  input  logic               in_fire_i,
  input  logic [ReqW-1:0]    in_req_i,
  input  logic [EntryW-1:0]  in_entry_i,
  input  logic [LinkW-1:0]   in_next_i,
  input  logic [LinkW-1:0]   in_first_i,
  input  logic [BytesW-1:0]  in_bytes_i,
  input  cmd_t               cmd_i,
  output status_t            status_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [OutDataW-1:0] out_data_o,
  output logic               out_summary_o,
  output logic               out_last_o
);

  localparam int unsigned IdxW  = (FatDepth > 1) ? $clog2(FatDepth) : 1;
  localparam int unsigned CntW  = $clog2(MaxFiles + 1);
  localparam int unsigned FileW = (MaxFiles > 1) ? $clog2(MaxFiles) : 1;
  localparam int unsigned AccW  = (IdxW + 11 > 32) ? IdxW + 12 : 33;
  localparam int unsigned FileDatW = LinkW + BytesW;

  // configuration
  logic [BsW-1:0]    block_size_q;
  logic [FatSzW-1:0] fat_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q <= BlockSizeRst;
      fat_size_q   <= FatSizeRst;
    end else if (cfg_fire_i) begin
      unique case (cfg_index_i)
        RegBlockSize: block_size_q <= cfg_data_i[BsW-1:0];
        RegFatSize:   fat_size_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [BsW-1:0] bs_eff;
  assign bs_eff = (block_size_q == '0) ? BsW'(1) : block_size_q;

  // walker registers
  logic [CntW-1:0]   count_q, fidx_q;
  logic [IdxW:0]     clr_q;
  logic [LinkW-1:0]  cur_q;
  logic [AccW-1:0]   acc_q;
  logic [BytesW-1:0] bytes_q;
  logic [FreeW-1:0]  distinct_q;
  logic [MaxFiles-1:0] few_q, many_q, loop_q, share_q;

  // link table
  logic             link_we;
  logic [IdxW-1:0]  cur_addr;
  logic [LinkW-1:0] link_rd;

  assign link_we  = in_fire_i && in_req_i == ReqLoad && 32'(in_entry_i) < FatDepth;
  assign cur_addr = IdxW'(cur_q[EntryW-1:0]);

  fcc_ram #(.Width(LinkW), .Depth(FatDepth)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (IdxW'(in_entry_i)),
    .wdata_i (in_next_i),
    .raddr_i (cur_addr),
    .rdata_o (link_rd)
  );

  // claimer and last visitor tags, one word per block
  logic              tag_we;
  logic [IdxW-1:0]   tag_waddr;
  logic [2*CntW-1:0] tag_wdata, tag_rd;
  logic [CntW-1:0]   claimer, visitor, my_tag;

  assign my_tag  = fidx_q + CntW'(1);
  assign claimer = tag_rd[2*CntW-1:CntW];
  assign visitor = tag_rd[CntW-1:0];

  always_comb begin
    tag_we    = cmd_i.clr_step;
    tag_waddr = clr_q[IdxW-1:0];
    tag_wdata = '0;
    if (cmd_i.walk_eval && visitor != my_tag) begin
      tag_we    = 1'b1;
      tag_waddr = cur_addr;
      tag_wdata = {(claimer == '0) ? my_tag : claimer, my_tag};
    end
  end

  fcc_ram #(.Width(2*CntW), .Depth(FatDepth)) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (tag_waddr),
    .wdata_i (tag_wdata),
    .raddr_i (cur_addr),
    .rdata_o (tag_rd)
  );

  // file entries
  logic                file_we;
  logic [FileDatW-1:0] file_rd;

  assign file_we = in_fire_i && in_req_i == ReqAppend && 32'(count_q) < MaxFiles;

  fcc_ram #(.Width(FileDatW), .Depth(MaxFiles)) u_file_ram (
    .clk_i   (clk_i),
    .we_i    (file_we),
    .waddr_i (count_q[FileW-1:0]),
    .wdata_i ({in_bytes_i, in_first_i}),
    .raddr_i (fidx_q[FileW-1:0]),
    .rdata_o (file_rd)
  );

  logic [FileW-1:0] fsel, osel;
  logic [AccW-1:0]  bytes_x, bs_x;
  assign fsel    = fidx_q[FileW-1:0];
  assign osel    = FileW'(claimer - CntW'(1));
  assign bytes_x = AccW'(bytes_q);
  assign bs_x    = AccW'(bs_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      fidx_q     <= '0;
      clr_q      <= '0;
      distinct_q <= '0;
      few_q      <= '0;
      many_q     <= '0;
      loop_q     <= '0;
      share_q    <= '0;
    end else begin
      if (file_we) begin
        count_q <= count_q + CntW'(1);
      end
      if (cmd_i.chk_start) begin
        fidx_q     <= '0;
        clr_q      <= '0;
        distinct_q <= '0;
        few_q      <= '0;
        many_q     <= '0;
        loop_q     <= '0;
        share_q    <= '0;
      end
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + (IdxW+1)'(1);
      end
      if (cmd_i.walk_eval) begin
        if (visitor == my_tag) begin
          loop_q[fsel] <= 1'b1;
        end else if (claimer == '0) begin
          distinct_q <= distinct_q + FreeW'(1);
        end else if (claimer != my_tag) begin
          share_q[fsel] <= 1'b1;
          share_q[osel] <= 1'b1;
        end
      end
      if (cmd_i.file_end) begin
        few_q[fsel]  <= bytes_x > acc_q;
        many_q[fsel] <= bytes_x + bs_x <= acc_q;
        fidx_q       <= fidx_q + CntW'(1);
      end
      if (cmd_i.emit_init) begin
        fidx_q <= '0;
      end
      if (cmd_i.emit_file) begin
        fidx_q <= fidx_q + CntW'(1);
      end
    end
  end

  // chain position and accumulated bytes covered
  always_ff @(posedge clk_i) begin
    if (cmd_i.chain_init) begin
      cur_q   <= file_rd[LinkW-1:0];
      bytes_q <= file_rd[FileDatW-1:LinkW];
      acc_q   <= '0;
    end else if (cmd_i.walk_eval && visitor != my_tag) begin
      cur_q <= link_rd;
      acc_q <= acc_q + bs_x;
    end
  end

  // output register
  logic out_valid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_file || cmd_i.emit_sum) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_file) begin
      out_data_o    <= {2'b00, FreeW'(0), share_q[fsel], loop_q[fsel], many_q[fsel],
                        few_q[fsel], FnumW'(fidx_q)};
      out_summary_o <= 1'b0;
      out_last_o    <= 1'b0;
    end else if (cmd_i.emit_sum) begin
      out_data_o    <= {2'b00, fat_size_q - distinct_q, 4'b0000, FnumW'(0)};
      out_summary_o <= 1'b1;
      out_last_o    <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    status_o.clr_done   = 32'(clr_q) >= 32'(fat_size_q) || 32'(clr_q) >= FatDepth;
    status_o.files_done = fidx_q == count_q;
    status_o.cur_ok     = !cur_q[LinkW-1] && 32'(cur_q[EntryW-1:0]) < 32'(fat_size_q)
                          && 32'(cur_q[EntryW-1:0]) < FatDepth;
    status_o.hit_loop   = visitor == my_tag;
    status_o.out_free   = !out_valid_q || out_ready_i;
  end

  a_distinct_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(distinct_q) <= FatDepth)
    else $error("distinct block count beyond table depth");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives table loads, file appends and check requests into the fat chain
// consistency checker, predicts every file flag result and the free block
// summary in a local model, and compares each result transaction in order
// ----------------------------------------------------------------------------
module testbench;
  import fcc_pkg::*;

  localparam int unsigned Depth    = FatDepthDef;
  localparam int unsigned NumFiles = MaxFilesDef;
  localparam logic [ReqW-1:0] ReqNone = 2'd3;  // unknown request kind

  typedef struct {
    logic [FnumW-1:0] file_number;
    logic             too_few;
    logic             too_many;
    logic             has_loop;
    logic             shares;
    logic             is_summary;
    logic [FreeW-1:0] free_blocks;
    logic             last;
  } verdict_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDatW-1:0]  cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [ReqW-1:0]     s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;
  logic                m_axis_tlast;

  // mirror of the block state
  int       link_mem [Depth];
  bit       link_loaded [Depth];
  int       loaded_idx [$];
  int       file_head [NumFiles];
  int       file_len_bytes [NumFiles];
  int       num_files;
  int       cur_block_size;
  int       cur_fat_size;
  verdict_t verdicts_due [$];

  int mismatches;
  int send_idle_pct;
  int recv_stall_pct;

  always #2 clk_i = ~clk_i;

  fat_chain_consistency_check dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // walk every file chain in load order and queue the flag results plus the summary
  task automatic predict_chain_walk();
    int       claimer [Depth];
    int       visitor [Depth];
    bit [3:0] flags [NumFiles];
    int       limit;
    int       bs;
    int       distinct;
    int       cur;
    int       owner;
    longint   need;
    longint   len;
    verdict_t v;
    limit = (cur_fat_size < Depth) ? cur_fat_size : Depth;
    bs = (cur_block_size == 0) ? 1 : cur_block_size;
    distinct = 0;
    foreach (claimer[b]) begin
      claimer[b] = 0;
      visitor[b] = 0;
    end
    foreach (flags[f]) flags[f] = '0;
    for (int f = 0; f < num_files; f++) begin
      cur = file_head[f];
      len = 0;
      need = (longint'(file_len_bytes[f]) + bs - 1) / bs;
      while (cur >= 0 && cur < limit) begin
        owner = claimer[cur];
        if (visitor[cur] == f + 1) begin
          flags[f][2] = 1'b1;  // loop back into own chain
          break;
        end
        if (owner == 0) begin
          claimer[cur] = f + 1;
          distinct++;
        end else if (owner != f + 1) begin
          flags[f][3] = 1'b1;
          flags[owner-1][3] = 1'b1;
        end
        visitor[cur] = f + 1;
        len++;
        cur = link_mem[cur];
      end
      if (need > len) flags[f][0] = 1'b1;
      if (need < len) flags[f][1] = 1'b1;
    end
    for (int f = 0; f < num_files; f++) begin
      v = '{file_number: f[FnumW-1:0], too_few: flags[f][0], too_many: flags[f][1],
            has_loop: flags[f][2], shares: flags[f][3], is_summary: 1'b0,
            free_blocks: '0, last: 1'b0};
      verdicts_due = {verdicts_due, v};
    end
    v = '{file_number: '0, too_few: 1'b0, too_many: 1'b0, has_loop: 1'b0, shares: 1'b0,
          is_summary: 1'b1, free_blocks: FreeW'(cur_fat_size - distinct), last: 1'b1};
    verdicts_due = {verdicts_due, v};
  endtask

  // send one request transaction and update the mirror once it is taken
  task automatic send_request(logic [ReqW-1:0] kind, int idx, int nxt, int head, int bytes);
    int gap;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 4);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {3'b000, bytes[BytesW-1:0], head[LinkW-1:0], nxt[LinkW-1:0],
                      idx[EntryW-1:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    case (kind)
      ReqLoad: begin
        link_mem[idx] = nxt;
        if (!link_loaded[idx]) loaded_idx = {loaded_idx, idx};
        link_loaded[idx] = 1'b1;
      end
      ReqAppend: begin
        if (num_files < NumFiles) begin
          file_head[num_files] = head;
          file_len_bytes[num_files] = bytes;
          num_files++;
        end
      end
      ReqCheck: predict_chain_walk();
      default: ;
    endcase
  endtask

  // pause until every result is back, then let a trailing load or append settle
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (verdicts_due.size() != 0);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, int value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value[CfgDatW-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    if (idx == RegBlockSize) cur_block_size = value;
    else cur_fat_size = value;
  endtask

  task automatic set_geometry(int bs, int fat);
    wait_drained();
    write_reg(RegBlockSize, bs);
    write_reg(RegFatSize, fat);
  endtask

  // link target that is always a loaded entry or end of chain
  function automatic int pick_link();
    if (loaded_idx.size() == 0 || $urandom_range(9) == 0) return -1;
    return loaded_idx[$urandom_range(loaded_idx.size() - 1)];
  endfunction

  function automatic int pick_bytes();
    case ($urandom_range(9))
      0: return $urandom_range(0, 1 << 30);
      1: return 0;
      default: return $urandom_range(0, 8 * cur_block_size);
    endcase
  endfunction

  // directed: short and long chains, loops, sharing, empty files, size extremes
  task automatic test_directed();
    send_request(ReqLoad, 0, 1, 0, 0);
    send_request(ReqLoad, 1, 2, 0, 0);
    send_request(ReqLoad, 2, -1, 0, 0);
    send_request(ReqLoad, 4095, 4095, 0, 0);  // self loop at the top entry
    send_request(ReqLoad, 10, 11, 0, 0);
    send_request(ReqLoad, 11, 10, 0, 0);
    send_request(ReqLoad, 20, 2, 0, 0);       // joins the first chain
    send_request(ReqAppend, 0, 0, 0, 1024);
    send_request(ReqAppend, 0, 0, 4095, 1 << 30);
    send_request(ReqAppend, 0, 0, 10, 0);
    send_request(ReqAppend, 0, 0, 20, 2047);
    send_request(ReqAppend, 0, 0, -1, 0);     // empty file
    send_request(ReqAppend, 0, 0, -1, (1 << 30) - 1);
    send_request(ReqNone, 4095, -1, -1, 32'h7fff_ffff);
    send_request(ReqCheck, 0, 0, 0, 0);
    // tiny table cuts chains short as out of range links
    set_geometry(1, 3);
    send_request(ReqCheck, 0, 0, 0, 0);
    set_geometry(1024, 4096);
    send_request(ReqCheck, 0, 0, 0, 0);
  endtask

  // random: mostly loads building chains over loaded entries, appends, few checks
  task automatic test_random(int count, int bs, int fat);
    int pick;
    int sent;
    int idx;
    set_geometry(bs, fat);
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        send_request(ReqNone, $urandom_range(4095), -1, -1, $urandom);
      end else if (pick < 10) begin
        send_request(ReqCheck, 0, 0, 0, 0);
        sent++;
      end else if (pick < 25 && num_files < NumFiles) begin
        send_request(ReqAppend, $urandom_range(4095), pick_link(), pick_link(), pick_bytes());
        sent++;
      end else begin
        idx = ($urandom_range(7) == 0) ? $urandom_range(4095) : $urandom_range(127);
        send_request(ReqLoad, idx, pick_link(), -1, $urandom_range(0, 1 << 30));
        sent++;
      end
    end
    send_request(ReqCheck, 0, 0, 0, 0);
  endtask

  // result checker with random back pressure
  always @(posedge clk_i) begin
    verdict_t v;
    if (m_axis_tvalid && m_axis_tready) begin
      if (verdicts_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction %h", m_axis_tdata);
      end else begin
        v = verdicts_due.pop_front();
        if (m_axis_tdata[4:0] !== v.file_number || m_axis_tdata[5] !== v.too_few ||
            m_axis_tdata[6] !== v.too_many || m_axis_tdata[7] !== v.has_loop ||
            m_axis_tdata[8] !== v.shares || m_axis_tdata[21:9] !== v.free_blocks ||
            m_axis_tuser !== v.is_summary || m_axis_tlast !== v.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp file %0d few %b many %b loop %b share %b",
                     v.file_number, v.too_few, v.too_many, v.has_loop, v.shares,
                     " sum %b free %0d last %b,", v.is_summary, v.free_blocks, v.last,
                     " got tdata %h tuser %b tlast %b", m_axis_tdata, m_axis_tuser,
                     m_axis_tlast);
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    #40ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    mismatches = 0;
    num_files = 0;
    cur_block_size = BlockSizeRst;
    cur_fat_size = FatSizeRst;
    foreach (link_loaded[i]) begin
      link_loaded[i] = 1'b0;
      link_mem[i] = 0;
    end
    send_idle_pct = 16;
    recv_stall_pct = 57;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(160, 512, 4096);
    send_idle_pct = 57;
    recv_stall_pct = 16;
    test_random(160, 1, 64);
    test_random(20, 1024, 1);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random(140, 37, 700);
    wait_drained();
    if (mismatches == 0 && verdicts_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
